// File: rtl/read_name_fnv1a64_hash_core_assert.svh
// Assertion macros used by the checker file.
`ifndef READ_NAME_FNV1A64_HASH_CORE_ASSERT_SVH
`define READ_NAME_FNV1A64_HASH_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RNFH_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rnfh assertion failed");

// Next-cycle implication, disabled in reset.
`define RNFH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rnfh assertion failed");

`endif

// File: rtl/rnfh_pkg.sv
`timescale 1ns / 1ps

package rnfh_pkg;

  // FNV-1a 64 offset basis; the prime is 2^40 + 0x1b3
  localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;

  localparam logic [7:0] ChAt    = 8'h40;  // '@'
  localparam logic [7:0] ChSlash = 8'h2f;  // '/'
  localparam logic [7:0] ChOne   = 8'h31;  // '1'
  localparam logic [7:0] ChTwo   = 8'h32;  // '2'
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChNul   = 8'h00;

  // Classified item passed from front to back
  typedef struct packed {
    logic       kept;   // byte goes into the hash
    logic [7:0] data;
    logic       last;   // closes the name
  } front_item_t;

  function automatic logic is_terminator(logic [7:0] b);
    return (b == ChNul) || (b == ChSpace) || (b == ChTab) || (b == ChCr) || (b == ChLf);
  endfunction

  // One FNV-1a step; multiply by the sparse prime as a sum of shifts
  function automatic logic [63:0] fnv_fold(logic [63:0] h, logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// File: rtl/rnfh_front.sv
`timescale 1ns / 1ps

module rnfh_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           name_byte_i,
  input  logic                 byte_present_i,
  input  logic                 last_byte_i,
  output logic                 push_o,
  output rnfh_pkg::front_item_t item_o,
  input  logic                 q_ready_i
);

  logic at_start_q, at_start_d;
  logic term_seen_q, term_seen_d;
  logic accept;
  logic kept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;

  // Classify the byte against name-start and terminator state
  always_comb begin
    kept        = 1'b0;
    at_start_d  = at_start_q;
    term_seen_d = term_seen_q;
    if (byte_present_i) begin
      at_start_d = 1'b0;
      if (at_start_q && (name_byte_i == rnfh_pkg::ChAt)) begin
        kept = 1'b0;
      end else if (term_seen_q) begin
        kept = 1'b0;
      end else if (rnfh_pkg::is_terminator(name_byte_i)) begin
        term_seen_d = 1'b1;
      end else begin
        kept = 1'b1;
      end
    end
    if (last_byte_i) begin
      at_start_d  = 1'b1;
      term_seen_d = 1'b0;
    end
  end

  // Items that neither add a byte nor close a name are dropped here
  assign push_o      = accept && (kept || last_byte_i);
  assign item_o.kept = kept;
  assign item_o.data = name_byte_i;
  assign item_o.last = last_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q  <= 1'b1;
      term_seen_q <= 1'b0;
    end else if (accept) begin
      at_start_q  <= at_start_d;
      term_seen_q <= term_seen_d;
    end
  end

endmodule

// File: rtl/rnfh_queue.sv
`timescale 1ns / 1ps

// Two-entry queue between front and back
module rnfh_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rnfh_pkg::front_item_t push_item_i,
  output logic                  ready_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output rnfh_pkg::front_item_t pop_item_o
);

  rnfh_pkg::front_item_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign ready_o    = (count_q != 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_item_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: rtl/rnfh_back.sv
`timescale 1ns / 1ps

module rnfh_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  rnfh_pkg::front_item_t item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [63:0]           name_hash_o
);

  logic [63:0] hash_all_q, hash_all_d;
  logic [63:0] hash_wo_q, hash_wo_d;
  logic [7:0]  tail0_q, tail0_d, tail1_q, tail1_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        out_valid_q;
  logic [63:0] out_hash_q;
  logic        out_free;
  logic        suffix;
  logic [63:0] result;

  // A closing item needs a free output register; others always go
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = q_valid_i && (!item_i.last || out_free);

  // Fold the kept byte into the full hash, and the byte two places back into the suffix-free hash
  always_comb begin
    hash_all_d = hash_all_q;
    hash_wo_d  = hash_wo_q;
    tail0_d    = tail0_q;
    tail1_d    = tail1_q;
    cnt_d      = cnt_q;
    if (item_i.kept) begin
      hash_all_d = rnfh_pkg::fnv_fold(hash_all_q, item_i.data);
      if (cnt_q >= 2'd2) begin
        hash_wo_d = rnfh_pkg::fnv_fold(hash_wo_q, tail0_q);
      end
      tail0_d = tail1_q;
      tail1_d = item_i.data;
      if (cnt_q != 2'd3) begin
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  // Pick the result: empty, mate suffix dropped, or full hash
  always_comb begin
    suffix = (cnt_d >= 2'd2) && (tail0_d == rnfh_pkg::ChSlash) &&
             ((tail1_d == rnfh_pkg::ChOne) || (tail1_d == rnfh_pkg::ChTwo));
    if (cnt_d == 2'd0) begin
      result = 64'd0;
    end else if (suffix) begin
      result = (cnt_d == 2'd2) ? 64'd0 : hash_wo_d;
    end else begin
      result = hash_all_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_all_q <= rnfh_pkg::FnvBasis;
      hash_wo_q  <= rnfh_pkg::FnvBasis;
      tail0_q    <= 8'd0;
      tail1_q    <= 8'd0;
      cnt_q      <= 2'd0;
    end else if (pop_o) begin
      if (item_i.last) begin
        hash_all_q <= rnfh_pkg::FnvBasis;
        hash_wo_q  <= rnfh_pkg::FnvBasis;
        tail0_q    <= 8'd0;
        tail1_q    <= 8'd0;
        cnt_q      <= 2'd0;
      end else begin
        hash_all_q <= hash_all_d;
        hash_wo_q  <= hash_wo_d;
        tail0_q    <= tail0_d;
        tail1_q    <= tail1_d;
        cnt_q      <= cnt_d;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && item_i.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.last) begin
      out_hash_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign name_hash_o = out_hash_q;

endmodule

// File: rtl/read_name_fnv1a64_hash_core.sv
`timescale 1ns / 1ps
// A name's last item passes through the queue, then its hash waits in the output register.
// One item per cycle unless the output stalls; the back folds each byte into two hashes.
// A two-entry queue parts the classifying front from the hashing back.
// Reset (rst_ni low, asynchronous) empties the queue and output and restores the
// offset basis and name-start state; no clearing pass is needed.

module read_name_fnv1a64_hash_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  name_byte_i,
  input  logic        byte_present_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] name_hash_o
);

  rnfh_pkg::front_item_t push_item, pop_item;
  logic push, q_ready, q_valid, pop;

  rnfh_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .name_byte_i    (name_byte_i),
    .byte_present_i (byte_present_i),
    .last_byte_i    (last_byte_i),
    .push_o         (push),
    .item_o         (push_item),
    .q_ready_i      (q_ready)
  );

  rnfh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  rnfh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .name_hash_o (name_hash_o)
  );

endmodule

// File: rtl/rnfh_checker.sv
`timescale 1ns / 1ps
`include "read_name_fnv1a64_hash_core_assert.svh"

module rnfh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        last_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] name_hash_o
);

  // Names closed at the input but not yet delivered
  logic [2:0] pend_q;
  logic       in_last_acc, out_acc;

  assign in_last_acc = in_valid_i && in_ready_o && last_byte_i;
  assign out_acc     = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else if (in_last_acc && !out_acc) begin
      pend_q <= pend_q + 3'd1;
    end else if (!in_last_acc && out_acc) begin
      pend_q <= pend_q - 3'd1;
    end
  end

  // A stalled result holds its value
  `RNFH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(name_hash_o))

  // No result without a closed name behind it
  `RNFH_ASSERT_IMPLY(a_no_spurious, clk_i, rst_ni, out_valid_o, pend_q != 3'd0)

  // Queue and output register hold at most three open names
  `RNFH_ASSERT_IMPLY(a_pend_bound, clk_i, rst_ni, pend_q == 3'd3, !in_ready_o)

endmodule

bind read_name_fnv1a64_hash_core rnfh_checker u_rnfh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_byte_i (last_byte_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .name_hash_o (name_hash_o)
);

// File: test/read_name_fnv1a64_hash_core_tb.sv
`timescale 1ns / 1ps

module read_name_fnv1a64_hash_core_tb;

  localparam logic [63:0] FnvOffset = 64'd14695981039346656037;
  localparam logic [63:0] FnvPrime  = 64'd1099511628211;
  localparam int unsigned RandItems = 750;
  localparam int unsigned CalmItems = 100;  // tail of the run with no idling
  localparam int unsigned DrainCycles = 8;

  // One input item, with an optional typed-in hash for the directed rows
  typedef struct packed {
    logic [7:0]  data;
    logic        present;
    logic        last;
    logic        typed;
    logic [63:0] typed_hash;
  } name_item_t;

  localparam int unsigned DirectedN = 24;

  // Directed rows: empty names, '@' handling, mate suffixes, every terminator,
  // byte extremes, absent bytes before the first byte
  localparam name_item_t DirectedRows [DirectedN] = '{
    '{8'h00,              1'b0, 1'b1, 1'b1, 64'd0},  // empty name item
    '{rnfh_pkg::ChAt,     1'b1, 1'b1, 1'b1, 64'd0},  // lone '@'
    '{rnfh_pkg::ChSlash,  1'b1, 1'b0, 1'b0, 64'd0},  // "/1" only
    '{rnfh_pkg::ChOne,    1'b1, 1'b1, 1'b1, 64'd0},
    '{rnfh_pkg::ChAt,     1'b1, 1'b0, 1'b0, 64'd0},  // "@/2"
    '{rnfh_pkg::ChSlash,  1'b1, 1'b0, 1'b0, 64'd0},
    '{rnfh_pkg::ChTwo,    1'b1, 1'b1, 1'b1, 64'd0},
    '{rnfh_pkg::ChSpace,  1'b1, 1'b1, 1'b1, 64'd0},  // cut right away
    '{"A",                1'b1, 1'b0, 1'b0, 64'd0},  // "A/1" keeps only "A"
    '{rnfh_pkg::ChSlash,  1'b1, 1'b0, 1'b0, 64'd0},
    '{rnfh_pkg::ChOne,    1'b1, 1'b1, 1'b0, 64'd0},
    '{"x",                1'b1, 1'b0, 1'b0, 64'd0},  // tab cut, 'y' ignored
    '{rnfh_pkg::ChTab,    1'b1, 1'b0, 1'b0, 64'd0},
    '{"y",                1'b1, 1'b1, 1'b0, 64'd0},
    '{8'hff,              1'b1, 1'b0, 1'b0, 64'd0},  // top byte then NUL
    '{rnfh_pkg::ChNul,    1'b1, 1'b1, 1'b0, 64'd0},
    '{8'hff,              1'b0, 1'b0, 1'b0, 64'd0},  // absent byte, '@' still leads
    '{rnfh_pkg::ChAt,     1'b1, 1'b0, 1'b0, 64'd0},
    '{"a",                1'b1, 1'b1, 1'b0, 64'd0},
    '{rnfh_pkg::ChAt,     1'b1, 1'b0, 1'b0, 64'd0},  // second '@' is kept
    '{rnfh_pkg::ChAt,     1'b1, 1'b1, 1'b0, 64'd0},
    '{"b",                1'b1, 1'b0, 1'b0, 64'd0},  // CR cut on the last item
    '{rnfh_pkg::ChCr,     1'b1, 1'b1, 1'b0, 64'd0},
    '{rnfh_pkg::ChLf,     1'b1, 1'b1, 1'b1, 64'd0}   // LF only
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  name_byte_i = 8'h00;
  logic        byte_present_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] name_hash_o;

  read_name_fnv1a64_hash_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .name_byte_i   (name_byte_i),
    .byte_present_i(byte_present_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .name_hash_o   (name_hash_o)
  );

  always #2 clk_i = ~clk_i;

  name_item_t  name_item_q [$];
  logic [63:0] name_hash_q [$];
  int unsigned err_n = 0;
  int unsigned sent_n = 0;
  int unsigned names_n = 0;
  int unsigned zero_n = 0;
  int unsigned mate_n = 0;

  // Hasher state mirrored from the block
  logic [63:0] hash_full;
  logic [63:0] hash_trim;
  logic [7:0]  tail_q [2];
  logic [1:0]  kept_n;
  logic        name_fresh;
  logic        cut_seen;

  function automatic logic [63:0] fnv_mix(logic [63:0] h, logic [7:0] d);
    return (h ^ {56'd0, d}) * FnvPrime;
  endfunction

  task automatic clear_name_state();
    hash_full  = FnvOffset;
    hash_trim  = FnvOffset;
    tail_q[0]  = 8'h00;
    tail_q[1]  = 8'h00;
    kept_n     = 2'd0;
    name_fresh = 1'b1;
    cut_seen   = 1'b0;
  endtask

  // Advance the mirror by one item; returns the name hash on a last item
  task automatic fold_name_item(input logic [7:0] d, input logic p, input logic l,
                                output logic [63:0] hash_v);
    logic skip;
    logic mate;
    skip = 1'b0;
    hash_v = 64'd0;
    if (p) begin
      if (name_fresh) begin
        name_fresh = 1'b0;
        skip = (d == rnfh_pkg::ChAt);
      end
      if (!skip && !cut_seen) begin
        if (d == rnfh_pkg::ChNul || d == rnfh_pkg::ChSpace || d == rnfh_pkg::ChTab ||
            d == rnfh_pkg::ChCr || d == rnfh_pkg::ChLf) begin
          cut_seen = 1'b1;
        end else begin
          hash_full = fnv_mix(hash_full, d);
          if (kept_n >= 2'd2) hash_trim = fnv_mix(hash_trim, tail_q[0]);
          tail_q[0] = tail_q[1];
          tail_q[1] = d;
          if (kept_n != 2'd3) kept_n = kept_n + 2'd1;
        end
      end
    end
    if (l) begin
      mate = (kept_n >= 2'd2) && (tail_q[0] == rnfh_pkg::ChSlash) &&
             (tail_q[1] == rnfh_pkg::ChOne || tail_q[1] == rnfh_pkg::ChTwo);
      if (kept_n == 2'd0) hash_v = 64'd0;
      else if (mate) hash_v = (kept_n == 2'd2) ? 64'd0 : hash_trim;
      else hash_v = hash_full;
      if (mate) mate_n++;
      clear_name_state();
    end
  endtask

  task automatic push_item(input logic [7:0] d, input logic p, input logic l);
    name_item_t it;
    it = '{d, p, l, 1'b0, 64'd0};
    name_item_q.push_back(it);
  endtask

  // Handshake driver and result checker
  name_item_t  cur_item;
  logic        holding = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned gap_odds = 4;
  int unsigned stall_odds = 4;

  always @(posedge clk_i) begin
    logic        calm;
    logic        nxt_ready;
    logic [63:0] hash_v;
    if (rst_ni) begin
      calm = (name_item_q.size() < CalmItems);

      // Result side: compare with the oldest expected hash
      if (out_valid_o && out_ready_i) begin
        if (name_hash_q.size() == 0) begin
          $error("name_hash: no result expected, got %h", name_hash_o);
          err_n++;
        end else begin
          hash_v = name_hash_q.pop_front();
          if (name_hash_o !== hash_v) begin
            $error("name_hash: expected %h, got %h", hash_v, name_hash_o);
            err_n++;
          end
        end
      end

      // Receiver stalls in bursts; stall density changes now and then
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 3))
          0: stall_odds = 0;
          1: stall_odds = 3;
          2: stall_odds = 8;
          default: stall_odds = 20;
        endcase
      end
      if (stall_left != 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        stall_left = $urandom_range(0, 18);
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready_i <= nxt_ready;

      // Item side: predict on acceptance, then present the next item
      if (in_valid_i && in_ready_o) begin
        fold_name_item(cur_item.data, cur_item.present, cur_item.last, hash_v);
        if (cur_item.last) begin
          if (cur_item.typed) hash_v = cur_item.typed_hash;
          name_hash_q.push_back(hash_v);
          names_n++;
          if (hash_v == 64'd0) zero_n++;
        end
        sent_n++;
        holding = 1'b0;
        if ($urandom_range(0, 39) == 0) begin
          case ($urandom_range(0, 3))
            0: gap_odds = 0;
            1: gap_odds = 3;
            2: gap_odds = 8;
            default: gap_odds = 20;
          endcase
        end
      end
      if (!holding) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
          gap_left = $urandom_range(0, 18);
        end else if (name_item_q.size() != 0) begin
          cur_item = name_item_q.pop_front();
          holding = 1'b1;
        end
      end
      in_valid_i <= holding;
      if (holding) begin
        name_byte_i    <= cur_item.data;
        byte_present_i <= cur_item.present;
        last_byte_i    <= cur_item.last;
      end else begin
        name_byte_i    <= 8'($urandom);
        byte_present_i <= 1'($urandom);
        last_byte_i    <= 1'($urandom);
      end
    end
  end

  // Stimulus build, reset and end of run
  initial begin
    string       body_chars;
    logic [7:0]  cut_chars [5];
    logic [7:0]  name_buf [$];
    logic        sep_close;
    int unsigned body_len;
    body_chars = "ACGTNacgtn0123456789:_-.#/";
    cut_chars = '{rnfh_pkg::ChNul, rnfh_pkg::ChSpace, rnfh_pkg::ChTab,
                  rnfh_pkg::ChCr, rnfh_pkg::ChLf};
    clear_name_state();

    foreach (DirectedRows[i]) name_item_q.push_back(DirectedRows[i]);

    // Mostly well-formed read names with random content, some raw noise
    while (name_item_q.size() < DirectedN + RandItems) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 9) == 0) push_item(8'($urandom), 1'b0, 1'b0);
        if ($urandom_range(0, 1) == 1) name_buf.push_back(rnfh_pkg::ChAt);
        body_len = $urandom_range(0, 10);
        repeat (body_len) begin
          if ($urandom_range(0, 19) == 0) name_buf.push_back(8'($urandom));
          else name_buf.push_back(body_chars[$urandom_range(0, body_chars.len() - 1)]);
        end
        case ($urandom_range(0, 4))
          0, 1: begin
            name_buf.push_back(rnfh_pkg::ChSlash);
            name_buf.push_back(($urandom_range(0, 1) == 1) ? rnfh_pkg::ChOne
                                                           : rnfh_pkg::ChTwo);
          end
          2: begin  // near miss on the mate suffix
            name_buf.push_back(rnfh_pkg::ChSlash);
            name_buf.push_back(body_chars[$urandom_range(0, body_chars.len() - 1)]);
          end
          default: ;
        endcase
        if ($urandom_range(0, 4) == 0) begin
          name_buf.push_back(cut_chars[$urandom_range(0, 4)]);
          repeat ($urandom_range(0, 3)) name_buf.push_back(8'($urandom));
        end
        sep_close = (name_buf.size() == 0) || ($urandom_range(0, 3) == 0);
        for (int k = 0; k < name_buf.size(); k++) begin
          if ($urandom_range(0, 19) == 0) push_item(8'($urandom), 1'b0, 1'b0);
          push_item(name_buf[k], 1'b1, !sep_close && (k == name_buf.size() - 1));
        end
        if (sep_close) push_item(8'($urandom), 1'b0, 1'b1);
        name_buf.delete();
      end else begin
        repeat ($urandom_range(1, 6))
          push_item(8'($urandom), 1'($urandom), ($urandom_range(0, 3) == 0));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (name_item_q.size() != 0 || in_valid_i || name_hash_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d items sent, %0d names hashed: %0d hashed to zero, %0d had a mate suffix",
             sent_n, names_n, zero_n, mate_n);
    if (err_n == 0 && name_hash_q.size() == 0) begin
      $display("read_name_fnv1a64_hash_core_tb passed");
    end else begin
      $display("read_name_fnv1a64_hash_core_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("read_name_fnv1a64_hash_core_tb failed");
    $finish;
  end

endmodule
